// ===== rtl/ionization_equilibrium_cell_update_top_assert.svh =====
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - assertion macros
// Clocked implication checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef IONIZATION_EQUILIBRIUM_CELL_UPDATE_TOP_ASSERT_SVH
`define IONIZATION_EQUILIBRIUM_CELL_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IEC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define IEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/iec_pkg.sv =====
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - package
// Field widths, register indexes, reset values and width helpers.
// ----------------------------------------------------------------------------
package iec_pkg;

  localparam int FieldW           = 32;
  localparam int CoeffW           = 32;
  localparam int ThrW             = 16;
  localparam int FracW            = 16;
  localparam int QuoW             = FracW + 1;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 32;
  localparam int DataWidthDefault = 32;
  localparam int DivStepsPerStage = 2;

  localparam logic [CfgIdxW-1:0] RegRecombCoeff   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFracThreshold = CfgIdxW'(1);

  localparam logic [CoeffW-1:0] RecombCoeffReset = CoeffW'(65536);
  localparam logic [ThrW-1:0]   FracThrReset     = ThrW'(655);
  localparam logic [QuoW-1:0]   OneQ16           = QuoW'(65536);

  // Density words never exceed the field width.
  function automatic int eff_width(input int dw);
    return (dw < FieldW) ? dw : FieldW;
  endfunction

endpackage

// ===== rtl/iec_front.sv =====
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - front stages
// Forms the selection test, the recombination term, the divisor and the
// total hydrogen over two register stages.
// ----------------------------------------------------------------------------
module iec_front #(
  parameter int  DataWidth = iec_pkg::DataWidthDefault,
  localparam int EffW      = iec_pkg::eff_width(DataWidth),
  localparam int RecW      = EffW + iec_pkg::CoeffW - iec_pkg::FracW,
  localparam int DenW      = RecW + 1,
  localparam int TotW      = EffW + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [EffW-1:0]           dens_i,
  input  logic [EffW-1:0]           elec_i,
  input  logic [EffW-1:0]           hi_i,
  input  logic [EffW-1:0]           hii_i,
  input  logic [EffW-1:0]           rate_i,
  input  logic [iec_pkg::CoeffW-1:0] coeff_i,
  input  logic [iec_pkg::ThrW-1:0]  thr_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic                      sel_o,
  output logic [EffW-1:0]           elec_o,
  output logic [EffW-1:0]           hi_o,
  output logic [EffW-1:0]           hii_o,
  output logic [EffW-1:0]           rate_o,
  output logic [DenW-1:0]           den_o,
  output logic [TotW-1:0]           total_h_o
);

  localparam int ThrProdW = iec_pkg::ThrW + EffW;
  localparam int RecProdW = iec_pkg::CoeffW + EffW;

  logic s1_v_q, s2_v_q;
  logic s1_rdy, s2_rdy;

  logic [EffW-1:0]     dens1_q, elec1_q, hi1_q, hii1_q, rate1_q;
  logic [ThrProdW-1:0] thr_prod_q;
  logic [RecProdW-1:0] rec_prod_q;

  logic            sel2_q;
  logic [EffW-1:0] elec2_q, hi2_q, hii2_q, rate2_q;
  logic [DenW-1:0] den2_q;
  logic [TotW-1:0] total2_q;

  assign s2_rdy  = !s2_v_q || ready_i;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Stage 1: the two products
  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      dens1_q    <= dens_i;
      elec1_q    <= elec_i;
      hi1_q      <= hi_i;
      hii1_q     <= hii_i;
      rate1_q    <= rate_i;
      thr_prod_q <= ThrProdW'(thr_i) * ThrProdW'(dens_i);
      rec_prod_q <= RecProdW'(coeff_i) * RecProdW'(elec_i);
    end
  end

  // Stage 2: selection compare, divisor and hydrogen sum
  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      sel2_q   <= (rate1_q != '0) && (dens1_q != '0) &&
                  ({elec1_q, {iec_pkg::FracW{1'b0}}} < thr_prod_q);
      den2_q   <= DenW'(rate1_q) + DenW'(rec_prod_q[RecProdW-1:iec_pkg::FracW]);
      total2_q <= TotW'(hi1_q) + TotW'(hii1_q);
      elec2_q  <= elec1_q;
      hi2_q    <= hi1_q;
      hii2_q   <= hii1_q;
      rate2_q  <= rate1_q;
    end
  end

  assign valid_o   = s2_v_q;
  assign sel_o     = sel2_q;
  assign elec_o    = elec2_q;
  assign hi_o      = hi2_q;
  assign hii_o     = hii2_q;
  assign rate_o    = rate2_q;
  assign den_o     = den2_q;
  assign total_h_o = total2_q;

endmodule

// ===== rtl/iec_div.sv =====
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - fraction divider
// Pipelined restoring divider for (rate << 16) / den, two quotient bits
// per stage, carrying the cell payload alongside.
// ----------------------------------------------------------------------------
module iec_div #(
  parameter int  DataWidth = iec_pkg::DataWidthDefault,
  parameter int  SideW     = 1,
  localparam int EffW      = iec_pkg::eff_width(DataWidth),
  localparam int DenW      = EffW + iec_pkg::CoeffW - iec_pkg::FracW + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [EffW-1:0]          rate_i,
  input  logic [DenW-1:0]          den_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [iec_pkg::QuoW-1:0] x_o,
  output logic [SideW-1:0]         side_o
);

  localparam int QuoW      = iec_pkg::QuoW;
  localparam int Sps       = iec_pkg::DivStepsPerStage;
  localparam int NumStages = (QuoW + Sps - 1) / Sps;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;
  logic [DenW-1:0]      rem_q  [NumStages];
  logic [DenW-1:0]      den_q  [NumStages];
  logic [QuoW-1:0]      quo_q  [NumStages];
  logic [SideW-1:0]     side_q [NumStages];

  assign rdy[NumStages] = ready_i;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [DenW-1:0]  rem_in, den_in, rem_nx;
    logic [QuoW-1:0]  quo_in, quo_nx;
    logic [SideW-1:0] side_in;
    logic             v_in;
    logic             first_bit;

    if (s == 0) begin : g_head
      // Numerator is rate << 16: start from rate >> 1 and shift in rate[0]
      assign rem_in    = DenW'(rate_i >> 1);
      assign den_in    = den_i;
      assign quo_in    = '0;
      assign side_in   = side_i;
      assign v_in      = valid_i;
      assign first_bit = rate_i[0];
    end else begin : g_body
      assign rem_in    = rem_q[s-1];
      assign den_in    = den_q[s-1];
      assign quo_in    = quo_q[s-1];
      assign side_in   = side_q[s-1];
      assign v_in      = v_q[s-1];
      assign first_bit = 1'b0;
    end

    always_comb begin
      logic [DenW:0] trial;
      rem_nx = rem_in;
      quo_nx = quo_in;
      trial  = '0;
      for (int j = 0; j < Sps; j++) begin
        if (s * Sps + j < QuoW) begin
          trial = {rem_nx, ((s == 0) && (j == 0)) ? first_bit : 1'b0};
          if (trial >= {1'b0, den_in}) begin
            rem_nx = DenW'(trial - {1'b0, den_in});
            quo_nx = {quo_nx[QuoW-2:0], 1'b1};
          end else begin
            rem_nx = trial[DenW-1:0];
            quo_nx = {quo_nx[QuoW-2:0], 1'b0};
          end
        end
      end
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        rem_q[s]  <= rem_nx;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_nx;
        side_q[s] <= side_in;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NumStages-1];
  assign x_o     = quo_q[NumStages-1];
  assign side_o  = side_q[NumStages-1];

endmodule

// ===== rtl/iec_back.sv =====
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - back stages
// Splits total hydrogen by the fraction, corrects the electron density,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module iec_back #(
  parameter int  DataWidth = iec_pkg::DataWidthDefault,
  localparam int EffW      = iec_pkg::eff_width(DataWidth),
  localparam int TotW      = EffW + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [iec_pkg::QuoW-1:0] x_i,
  input  logic                     sel_i,
  input  logic [EffW-1:0]          elec_i,
  input  logic [EffW-1:0]          hi_i,
  input  logic [EffW-1:0]          hii_i,
  input  logic [TotW-1:0]          total_h_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [EffW-1:0]          electron_o,
  output logic [EffW-1:0]          neutral_o,
  output logic [EffW-1:0]          ionized_o,
  output logic                     updated_o
);

  localparam int ProdW = TotW + iec_pkg::QuoW;
  localparam int EsW   = TotW + 2;

  logic a_v_q, b_v_q;
  logic a_rdy, b_rdy;

  logic [ProdW-1:0] prod_q;
  logic             sel_a_q;
  logic [EffW-1:0]  elec_a_q, hi_a_q, hii_a_q;
  logic [TotW-1:0]  total_a_q;

  logic [TotW-1:0] new_hii, new_hi;
  logic [EsW-1:0]  e_sum;
  logic [EffW-1:0] e_sat, hi_sat, hii_sat;

  logic [EffW-1:0] electron_q, neutral_q, ionized_q;
  logic            updated_q;

  assign b_rdy   = !b_v_q || ready_i;
  assign a_rdy   = !a_v_q || b_rdy;
  assign ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_q <= valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
    end
  end

  // Stage A: ionized share product
  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      prod_q    <= ProdW'(total_h_i) * ProdW'(x_i);
      sel_a_q   <= sel_i;
      elec_a_q  <= elec_i;
      hi_a_q    <= hi_i;
      hii_a_q   <= hii_i;
      total_a_q <= total_h_i;
    end
  end

  // The fraction never exceeds one, so the ionized share fits the total's width
  assign new_hii = prod_q[iec_pkg::FracW +: TotW];
  assign new_hi  = total_a_q - new_hii;
  // Top bit of e_sum is the sign of the exact electron value
  assign e_sum   = EsW'(elec_a_q) + EsW'(new_hii) - EsW'(hii_a_q);

  always_comb begin
    if (e_sum[EsW-1]) begin
      e_sat = '0;
    end else if (e_sum[EsW-2:EffW] != '0) begin
      e_sat = '1;
    end else begin
      e_sat = e_sum[EffW-1:0];
    end
    hi_sat  = new_hi[TotW-1]  ? '1 : new_hi[EffW-1:0];
    hii_sat = new_hii[TotW-1] ? '1 : new_hii[EffW-1:0];
  end

  // Stage B: output register
  always_ff @(posedge clk_i) begin
    if (b_rdy) begin
      if (sel_a_q) begin
        electron_q <= e_sat;
        neutral_q  <= hi_sat;
        ionized_q  <= hii_sat;
      end else begin
        electron_q <= elec_a_q;
        neutral_q  <= hi_a_q;
        ionized_q  <= hii_a_q;
      end
      updated_q <= sel_a_q;
    end
  end

  assign valid_o    = b_v_q;
  assign electron_o = electron_q;
  assign neutral_o  = neutral_q;
  assign ionized_o  = ionized_q;
  assign updated_o  = updated_q;

endmodule

// ===== rtl/ionization_equilibrium_cell_update_top.sv =====
// Throughput: one cell per cycle unless out_ready_i stalls the output.
// Stages: 2 front stages, 9 divider stages at 2 quotient bits each, and
// 2 back stages, all advancing independently.
// Reset: rst_ni low clears every stage valid bit and loads the
// recombination coefficient (1.0) and fraction threshold (655) defaults.
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - top level
// Selects cells below the electron fraction threshold and resets their
// hydrogen split and electron density to photoionization equilibrium.
// ----------------------------------------------------------------------------
module ionization_equilibrium_cell_update_top #(
  parameter int DATA_WIDTH = iec_pkg::DataWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [iec_pkg::FieldW-1:0]  gas_density_i,
  input  logic [iec_pkg::FieldW-1:0]  electron_density_i,
  input  logic [iec_pkg::FieldW-1:0]  neutral_h_density_i,
  input  logic [iec_pkg::FieldW-1:0]  ionized_h_density_i,
  input  logic [iec_pkg::FieldW-1:0]  photo_rate_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [iec_pkg::FieldW-1:0]  electron_out_o,
  output logic [iec_pkg::FieldW-1:0]  neutral_h_out_o,
  output logic [iec_pkg::FieldW-1:0]  ionized_h_out_o,
  output logic                        was_updated_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [iec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [iec_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int EffW  = iec_pkg::eff_width(DATA_WIDTH);
  localparam int DenW  = EffW + iec_pkg::CoeffW - iec_pkg::FracW + 1;
  localparam int TotW  = EffW + 1;
  localparam int SideW = 1 + 3 * EffW + TotW;

  logic [iec_pkg::CoeffW-1:0] coeff_q;
  logic [iec_pkg::ThrW-1:0]   thr_q;

  logic            f_valid, f_ready, f_sel;
  logic [EffW-1:0] f_elec, f_hi, f_hii, f_rate;
  logic [DenW-1:0] f_den;
  logic [TotW-1:0] f_total;
  logic [SideW-1:0] f_side;

  logic                     d_valid, d_ready, d_sel;
  logic [iec_pkg::QuoW-1:0] d_x;
  logic [SideW-1:0]         d_side;
  logic [EffW-1:0]          d_elec, d_hi, d_hii;
  logic [TotW-1:0]          d_total;

  logic [EffW-1:0] b_elec, b_hi, b_hii;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= iec_pkg::RecombCoeffReset;
      thr_q   <= iec_pkg::FracThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        iec_pkg::RegRecombCoeff: begin
          coeff_q <= cfg_data_i[iec_pkg::CoeffW-1:0];
        end
        iec_pkg::RegFracThreshold: begin
          thr_q <= cfg_data_i[iec_pkg::ThrW-1:0];
        end
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  iec_front #(
    .DataWidth(DATA_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .dens_i   (gas_density_i[EffW-1:0]),
    .elec_i   (electron_density_i[EffW-1:0]),
    .hi_i     (neutral_h_density_i[EffW-1:0]),
    .hii_i    (ionized_h_density_i[EffW-1:0]),
    .rate_i   (photo_rate_i[EffW-1:0]),
    .coeff_i  (coeff_q),
    .thr_i    (thr_q),
    .valid_o  (f_valid),
    .ready_i  (f_ready),
    .sel_o    (f_sel),
    .elec_o   (f_elec),
    .hi_o     (f_hi),
    .hii_o    (f_hii),
    .rate_o   (f_rate),
    .den_o    (f_den),
    .total_h_o(f_total)
  );

  assign f_side = {f_sel, f_elec, f_hi, f_hii, f_total};

  iec_div #(
    .DataWidth(DATA_WIDTH),
    .SideW    (SideW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(f_valid),
    .ready_o(f_ready),
    .rate_i (f_rate),
    .den_i  (f_den),
    .side_i (f_side),
    .valid_o(d_valid),
    .ready_i(d_ready),
    .x_o    (d_x),
    .side_o (d_side)
  );

  assign {d_sel, d_elec, d_hi, d_hii, d_total} = d_side;

  iec_back #(
    .DataWidth(DATA_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (d_valid),
    .ready_o   (d_ready),
    .x_i       (d_x),
    .sel_i     (d_sel),
    .elec_i    (d_elec),
    .hi_i      (d_hi),
    .hii_i     (d_hii),
    .total_h_i (d_total),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .electron_o(b_elec),
    .neutral_o (b_hi),
    .ionized_o (b_hii),
    .updated_o (was_updated_o)
  );

  assign electron_out_o  = iec_pkg::FieldW'(b_elec);
  assign neutral_h_out_o = iec_pkg::FieldW'(b_hi);
  assign ionized_h_out_o = iec_pkg::FieldW'(b_hii);

`include "ionization_equilibrium_cell_update_top_assert.svh"

  // Input backs up only when every stage is full and the output is stalled
  `IEC_ASSERT_IMPLIES(a_full_when_blocked, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  // Divisor includes the rate, so the fraction of a selected cell is at most one
  `IEC_ASSERT_IMPLIES(a_frac_bounded, clk_i, rst_ni, d_valid && d_sel, d_x <= iec_pkg::OneQ16)
  `IEC_ASSERT_NEXT(a_thr_written, clk_i, rst_ni, cfg_valid_i && cfg_index_i == iec_pkg::RegFracThreshold, thr_q == $past(cfg_data_i[iec_pkg::ThrW-1:0]))

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Ionization equilibrium cell update - testbench
// Streams grid cells through the block, both directed and random, under
// bursty input and a stalling output, and over several register settings.
// Each result is compared with a local fixed-point model of the correction.
// ----------------------------------------------------------------------------
module testbench;
  import iec_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 32;
  // Indexes that decode to no register; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpareTwo   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareThree = CfgIdxW'(3);
  localparam logic [63:0] WordMax = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [FieldW-1:0] gas;
    logic [FieldW-1:0] elec;
    logic [FieldW-1:0] neutral;
    logic [FieldW-1:0] ionized;
    logic [FieldW-1:0] rate;
  } cell_t;

  typedef struct packed {
    logic [FieldW-1:0] elec;
    logic [FieldW-1:0] neutral;
    logic [FieldW-1:0] ionized;
    logic              updated;
  } cell_fix_t;

  typedef enum logic [1:0] {
    ReadyAlways, ReadyCoinFlip, ReadyThreeOfFour, ReadyScarce
  } ready_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [FieldW-1:0]   gas_density_i = '0;
  logic [FieldW-1:0]   electron_density_i = '0;
  logic [FieldW-1:0]   neutral_h_density_i = '0;
  logic [FieldW-1:0]   ionized_h_density_i = '0;
  logic [FieldW-1:0]   photo_rate_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FieldW-1:0]   electron_out_o;
  logic [FieldW-1:0]   neutral_h_out_o;
  logic [FieldW-1:0]   ionized_h_out_o;
  logic                was_updated_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cell_t     cells_to_send[$];
  cell_fix_t expected_fixes[$];
  cell_t     cell_on_bus;
  cell_fix_t fix_want;

  logic [CoeffW-1:0] coeff_now = RecombCoeffReset;
  logic [ThrW-1:0]   thr_now = FracThrReset;

  int error_count = 0;
  int cells_sent = 0;
  int cells_corrected = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_span = 0;
  int quiet_cycles = 0;
  logic [1:0]  ready_beat = '0;
  ready_mode_e ready_mode = ReadyAlways;

  ionization_equilibrium_cell_update_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .gas_density_i       (gas_density_i),
    .electron_density_i  (electron_density_i),
    .neutral_h_density_i (neutral_h_density_i),
    .ionized_h_density_i (ionized_h_density_i),
    .photo_rate_i        (photo_rate_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .electron_out_o      (electron_out_o),
    .neutral_h_out_o     (neutral_h_out_o),
    .ionized_h_out_o     (ionized_h_out_o),
    .was_updated_o       (was_updated_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Selection test, equilibrium fraction, hydrogen split and electron update.
  function automatic cell_fix_t solve_equilibrium(input cell_t c, input logic [CoeffW-1:0] coeff,
                                                  input logic [ThrW-1:0] thr);
    logic [63:0] gas64, elec64, hi64, hii64, rate64;
    logic [63:0] recomb, denom, frac, h_total, hii_new, hi_new;
    logic signed [63:0] e;
    cell_fix_t r;
    gas64  = {32'b0, c.gas};
    elec64 = {32'b0, c.elec};
    hi64   = {32'b0, c.neutral};
    hii64  = {32'b0, c.ionized};
    rate64 = {32'b0, c.rate};
    r.updated = (rate64 != 0) && (gas64 != 0) && ((elec64 << 16) < ({48'b0, thr} * gas64));
    if (!r.updated) begin
      r.elec    = c.elec;
      r.neutral = c.neutral;
      r.ionized = c.ionized;
      return r;
    end
    recomb  = ({32'b0, coeff} * elec64) >> 16;
    denom   = rate64 + recomb;
    frac    = (rate64 << 16) / denom;
    h_total = hi64 + hii64;
    hii_new = (h_total * frac) >> 16;
    hi_new  = h_total - hii_new;
    e = $signed(elec64) + $signed(hii_new) - $signed(hii64);
    if (e < 0) r.elec = '0;
    else if (e > $signed(WordMax)) r.elec = '1;
    else r.elec = e[FieldW-1:0];
    r.neutral = (hi_new > WordMax) ? '1 : hi_new[FieldW-1:0];
    r.ionized = (hii_new > WordMax) ? '1 : hii_new[FieldW-1:0];
    return r;
  endfunction

  // Random word of random magnitude, all ones now and then.
  function automatic logic [FieldW-1:0] rand_word();
    int unsigned nbits;
    logic [FieldW-1:0] v;
    nbits = $urandom_range(0, FieldW);
    v = $urandom;
    if (nbits < FieldW) v = v & ((32'd1 << nbits) - 32'd1);
    if ($urandom_range(0, 15) == 0) v = '1;
    return v;
  endfunction

  task automatic queue_cell(input logic [FieldW-1:0] gas, elec, hi, hii, rate);
    cell_t c;
    c = '{gas: gas, elec: elec, neutral: hi, ionized: hii, rate: rate};
    cells_to_send.push_back(c);
  endtask

  // Mostly cells built to pass the fraction test, the rest raw noise.
  task automatic queue_random_cells(input int count);
    cell_t c;
    logic [63:0] prod, elec_max;
    for (int i = 0; i < count; i++) begin
      c.gas = rand_word();
      c.elec = $urandom;
      c.neutral = ($urandom_range(0, 1) == 0) ? rand_word() : $urandom;
      c.ionized = ($urandom_range(0, 1) == 0) ? rand_word() : $urandom;
      c.rate = rand_word();
      if ($urandom_range(0, 3) != 0) begin
        if (c.gas == 0) c.gas = $urandom | 32'd1;
        if (c.rate == 0) c.rate = $urandom | 32'd1;
        prod = {48'b0, thr_now} * {32'b0, c.gas};
        if (prod != 0) begin
          elec_max = (prod - 64'd1) >> 16;
          case ($urandom_range(0, 7))
            0: c.elec = elec_max[FieldW-1:0];
            1: c.elec = elec_max[FieldW-1:0] + 32'd1;
            2: c.elec = '0;
            3: c.elec = 32'($urandom_range(0, 32'(elec_max)));
            default: c.elec = 32'({32'b0, rand_word()} % (elec_max + 64'd1));
          endcase
        end
      end else if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) c.gas = '0;
        else c.rate = '0;
      end
      cells_to_send.push_back(c);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    if (idx == RegRecombCoeff) coeff_now = data[CoeffW-1:0];
    else if (idx == RegFracThreshold) thr_now = data[ThrW-1:0];
  endtask

  // Sample at the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cells_to_send.size() != 0 || in_valid_i || expected_fixes.size() != 0);
  endtask

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_fixes.push_back(solve_equilibrium(cell_on_bus, coeff_now, thr_now));
        cells_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (cells_to_send.size() != 0) begin
          cell_on_bus = cells_to_send.pop_front();
          gas_density_i       <= cell_on_bus.gas;
          electron_density_i  <= cell_on_bus.elec;
          neutral_h_density_i <= cell_on_bus.neutral;
          ionized_h_density_i <= cell_on_bus.ionized;
          photo_rate_i        <= cell_on_bus.rate;
          in_valid_i          <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output ready: switch between randomly chosen stall patterns, each held for a random span.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_mode  <= ReadyAlways;
      ready_span  <= 0;
      ready_beat  <= '0;
    end else begin
      ready_beat <= ready_beat + 2'd1;
      if (ready_span == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        ready_span <= $urandom_range(20, 200);
      end else begin
        ready_span <= ready_span - 1;
      end
      case (ready_mode)
        ReadyAlways:      out_ready_i <= 1'b1;
        ReadyCoinFlip:    out_ready_i <= $urandom_range(0, 1);
        ReadyThreeOfFour: out_ready_i <= (ready_beat != 2'd0);
        default:          out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fixes.size() == 0) begin
        flag_error("result with no cell waiting");
      end else begin
        fix_want = expected_fixes.pop_front();
        if (fix_want.updated) cells_corrected++;
        if (electron_out_o !== fix_want.elec)
          flag_error($sformatf("electron_out got %h want %h", electron_out_o, fix_want.elec));
        if (neutral_h_out_o !== fix_want.neutral)
          flag_error($sformatf("neutral_h_out got %h want %h", neutral_h_out_o,
                               fix_want.neutral));
        if (ionized_h_out_o !== fix_want.ionized)
          flag_error($sformatf("ionized_h_out got %h want %h", ionized_h_out_o,
                               fix_want.ionized));
        if (was_updated_o !== fix_want.updated)
          flag_error($sformatf("was_updated got %b want %b", was_updated_o, fix_want.updated));
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("FAIL ionization_equilibrium_cell_update_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero density, zero rate, extremes, threshold edge.
    queue_cell('0, '0, '0, '0, '0);
    queue_cell('0, 32'h0000_1000, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000);
    queue_cell(32'h0064_0000, '0, 32'h005A_0000, 32'h000A_0000, '0);
    queue_cell('1, '1, '1, '1, '1);
    queue_cell(32'h0064_0000, 32'd65500, 32'h005A_0000, 32'h000A_0000, 32'h0001_0000);
    queue_cell(32'h0064_0000, 32'd65499, 32'h005A_0000, 32'h000A_0000, 32'h0001_0000);
    queue_cell(32'h0064_0000, 32'h0000_8000, 32'h005A_0000, 32'h000A_0000, 32'h0001_0000);
    queue_cell(32'h0064_0000, '0, 32'h005A_0000, 32'h000A_0000, 32'd1);
    queue_cell('1, '0, '1, '1, '1);
    queue_cell('1, 32'd1, '0, '1, 32'd1);
    queue_cell('1, 32'h0080_0000, '1, '0, 32'd1);
    queue_cell(32'd1, '0, 32'h0000_0001, 32'h0000_0001, '1);
    queue_cell(32'hAAAA_5555, 32'h0000_5555, 32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA);
    wait_idle();

    // No recombination, widest threshold: electron and hydrogen overflow.
    write_reg(RegRecombCoeff, '0);
    write_reg(RegFracThreshold, 32'h0000_FFFF);
    queue_cell('1, 32'h8000_0000, 32'h9000_0000, 32'h0000_0001, 32'd1);
    queue_cell('1, 32'h1234_0000, '1, '1, 32'h0000_0100);
    queue_cell('1, 32'hFFFE_FFFF, '1, '0, '1);
    queue_cell(32'h0000_0001, '0, 32'h0000_FFFF, 32'h0000_0001, 32'd7);
    queue_random_cells(220);
    wait_idle();

    // Largest coefficient with a zero threshold: nothing is selected.
    write_reg(RegRecombCoeff, '1);
    write_reg(RegFracThreshold, 32'h0000_0000);
    queue_random_cells(120);
    wait_idle();

    // Smallest nonzero settings; junk above the threshold field.
    write_reg(RegFracThreshold, 32'hFFFF_0001);
    write_reg(RegRecombCoeff, 32'd1);
    queue_random_cells(220);
    wait_idle();

    // Writes to unused indexes leave both registers alone.
    write_reg(RegSpareTwo, $urandom);
    write_reg(RegSpareThree, $urandom);
    queue_random_cells(220);
    wait_idle();

    repeat (4) begin
      write_reg(RegRecombCoeff, rand_word());
      write_reg(RegFracThreshold, $urandom);
      queue_random_cells(220);
      wait_idle();
    end

    write_reg(RegRecombCoeff, {16'hFFFF, 16'h0000} & 32'h0001_0000);
    write_reg(RegFracThreshold, {16'hABCD, 16'(FracThrReset)});
    queue_random_cells(220);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_fixes.size() != 0)
      flag_error($sformatf("%0d cells never came back", expected_fixes.size()));

    $display("run covered %0d cells, %0d of them corrected, over %0d register writes",
             cells_sent, cells_corrected, reg_writes);
    $display("mismatches found: %0d", error_count);
    if (error_count == 0) begin
      $display("PASS ionization_equilibrium_cell_update_top");
    end else begin
      $display("FAIL ionization_equilibrium_cell_update_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/iec_pkg.sv
rtl/iec_front.sv
rtl/iec_div.sv
rtl/iec_back.sv
rtl/ionization_equilibrium_cell_update_top.sv
sim/testbench.sv
